// ----- rtl/tfp_pkg.sv -----
// Package for the telemetry frame parser.
// Holds field widths, configuration register indexes and default parameter values.
// No dependencies.
`default_nettype none

package tfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int VALUE_W     = 16;
    localparam int PLEN_W      = 6;
    localparam int FCOUNT_W    = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int PAYLOAD_KEPT = 6;

    localparam int FRAME_LIMIT_DEFAULT = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_VALUE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECKSUM_SEED  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_LEN   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAME      = 2'd3;

    localparam logic [PLEN_W-1:0]   EXPECTED_LEN_RESET = 6'd6;
    localparam logic [FCOUNT_W-1:0] MAX_FRAME_RESET    = 7'd64;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage : tfp_pkg

`default_nettype wire

// ----- rtl/telemetry_frame_parser.sv -----
// Top level of the telemetry frame parser: byte-serial parser for XOR-checksummed frames.
// Depends on tfp_pkg for widths, register indexes and defaults.
`default_nettype none

// The parser takes one received byte per clock, sustaining one byte per cycle
// unless a held result stalls it. A byte is held in an input register; from there
// it updates the frame state and, when it completes a frame with a good checksum,
// loads the result register. The result register separates the two sides: one
// more byte can enter the input register while a result waits to be taken, and
// the input stalls only when a byte waits in the input register while the result
// is still held. Configuration may be written only while idle.
module telemetry_frame_parser
#(
    parameter int FRAME_LIMIT = tfp_pkg::FRAME_LIMIT_DEFAULT
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            cfg_write,
    input  wire logic [tfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tfp_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                            in_valid,
    output      logic                            in_ready,
    input  wire logic [tfp_pkg::BYTE_W-1:0]      rx_byte,

    output      logic                            out_valid,
    input  wire logic                            out_ready,
    output      logic [tfp_pkg::VALUE_W-1:0]     voltage_tenths,
    output      logic [tfp_pkg::VALUE_W-1:0]     current_tenths,
    output      logic [tfp_pkg::VALUE_W-1:0]     temperature_tenths,
    output      logic [tfp_pkg::BYTE_W-1:0]      source_device,
    output      logic [tfp_pkg::BYTE_W-1:0]      command_code
);

    import tfp_pkg::*;

    localparam int LIMIT_W = $clog2(FRAME_LIMIT + 1);
    localparam int CMP_W   = (LIMIT_W > FCOUNT_W) ? LIMIT_W : FCOUNT_W;
    localparam logic [CMP_W-1:0] LIMIT_C = CMP_W'(FRAME_LIMIT);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CSUM,
        PH_DEVICE,
        PH_COMMAND,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD
    } phase_t;

    byte_t               header_value_reg;
    byte_t               checksum_seed_reg;
    logic [PLEN_W-1:0]   expected_len_reg;
    logic [FCOUNT_W-1:0] max_frame_reg;

    logic  in_full_reg;
    byte_t in_byte_reg;

    phase_t              phase_reg, phase_next;
    logic [FCOUNT_W-1:0] fcount_reg, fcount_next;
    logic [PLEN_W-1:0]   pcount_reg, pcount_next;
    byte_t               xor_reg, xor_next;
    byte_t               csum_reg, csum_next;
    byte_t               device_reg, device_next;
    byte_t               command_reg, command_next;
    byte_t               len_lo_reg, len_lo_next;
    byte_t               payload_reg  [PAYLOAD_KEPT];
    byte_t               payload_next [PAYLOAD_KEPT];

    logic  out_valid_reg;
    logic  [VALUE_W-1:0] volt_reg, curr_reg, temp_reg;
    byte_t src_reg, cmd_reg;

    logic emit;
    logic step;

    assign step     = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_value_reg  <= '0;
            checksum_seed_reg <= '0;
            expected_len_reg  <= EXPECTED_LEN_RESET;
            max_frame_reg     <= MAX_FRAME_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_HEADER_VALUE:  header_value_reg  <= cfg_data;
                CFG_CHECKSUM_SEED: checksum_seed_reg <= cfg_data;
                CFG_EXPECTED_LEN:  expected_len_reg  <= cfg_data[PLEN_W-1:0];
                CFG_MAX_FRAME:     max_frame_reg     <= cfg_data[FCOUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        logic [CMP_W-1:0] max_ext;
        logic [CMP_W-1:0] limit;
        logic             again;
        byte_t            b;

        b       = in_byte_reg;
        max_ext = CMP_W'(max_frame_reg);
        limit   = (max_ext > LIMIT_C) ? LIMIT_C : max_ext;

        phase_next   = phase_reg;
        fcount_next  = fcount_reg + 1'b1;
        pcount_next  = pcount_reg;
        xor_next     = xor_reg;
        csum_next    = csum_reg;
        device_next  = device_reg;
        command_next = command_reg;
        len_lo_next  = len_lo_reg;
        payload_next = payload_reg;
        emit         = 1'b0;
        again        = (CMP_W'(fcount_next) >= limit);

        case (phase_reg)
            PH_CSUM:
            begin
                csum_next  = b;
                phase_next = PH_DEVICE;
            end
            PH_DEVICE:
            begin
                device_next = b;
                xor_next    = xor_reg ^ b;
                phase_next  = PH_COMMAND;
            end
            PH_COMMAND:
            begin
                command_next = b;
                xor_next     = xor_reg ^ b;
                phase_next   = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_lo_next = b;
                xor_next    = xor_reg ^ b;
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                xor_next = xor_reg ^ b;
                if (b == '0 && len_lo_reg == BYTE_W'(expected_len_reg))
                begin
                    phase_next = PH_PAYLOAD;
                end
                else
                begin
                    again = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                xor_next = xor_reg ^ b;
                for (int i = 0; i < PAYLOAD_KEPT; i++)
                begin
                    if (pcount_reg == PLEN_W'(i))
                    begin
                        payload_next[i] = b;
                    end
                end
                pcount_next = pcount_reg + 1'b1;
                if (pcount_next >= expected_len_reg)
                begin
                    emit  = ((xor_next ^ checksum_seed_reg) == csum_reg);
                    again = 1'b1;
                end
            end
            default:
            begin
                xor_next = '0;
                if (b == header_value_reg)
                begin
                    phase_next = PH_CSUM;
                end
                else
                begin
                    again = 1'b1;
                end
            end
        endcase

        if (again)
        begin
            phase_next  = PH_HEADER;
            fcount_next = '0;
            pcount_next = '0;
            xor_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HEADER;
            fcount_reg    <= '0;
            pcount_reg    <= '0;
            xor_reg       <= '0;
            csum_reg      <= '0;
            device_reg    <= '0;
            command_reg   <= '0;
            len_lo_reg    <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_full_reg <= in_valid;
            end
            if (step && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (step)
            begin
                phase_reg   <= phase_next;
                fcount_reg  <= fcount_next;
                pcount_reg  <= pcount_next;
                xor_reg     <= xor_next;
                csum_reg    <= csum_next;
                device_reg  <= device_next;
                command_reg <= command_next;
                len_lo_reg  <= len_lo_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step)
        begin
            payload_reg <= payload_next;
            if (emit)
            begin
                volt_reg <= {payload_next[1], payload_next[0]};
                curr_reg <= {payload_next[3], payload_next[2]};
                temp_reg <= {payload_next[5], payload_next[4]};
                src_reg  <= device_reg;
                cmd_reg  <= command_reg;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign voltage_tenths     = volt_reg;
    assign current_tenths     = curr_reg;
    assign temperature_tenths = temp_reg;
    assign source_device      = src_reg;
    assign command_code       = cmd_reg;

endmodule : telemetry_frame_parser

`default_nettype wire

// ----- rtl/tfp_checker.sv -----
// Port-level checker for the telemetry frame parser, bound to its top level.
// Depends on tfp_pkg for field widths.
`default_nettype none

module tfp_checker
(
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_ready,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [tfp_pkg::VALUE_W-1:0]     voltage_tenths,
    input wire logic [tfp_pkg::VALUE_W-1:0]     current_tenths,
    input wire logic [tfp_pkg::VALUE_W-1:0]     temperature_tenths,
    input wire logic [tfp_pkg::BYTE_W-1:0]      source_device,
    input wire logic [tfp_pkg::BYTE_W-1:0]      command_code
);

    // A result that is not taken stays offered with the same contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(voltage_tenths)
            && $stable(current_tenths) && $stable(temperature_tenths)
            && $stable(source_device) && $stable(command_code))
        else $error("result changed or vanished while stalled");

    // No result is offered in the cycle after reset is seen.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result offered during reset");

    // With the result register empty the input side never stalls.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    // The input can only stall while a result is being held back.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

endmodule : tfp_checker

bind telemetry_frame_parser tfp_checker u_tfp_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .voltage_tenths     (voltage_tenths),
    .current_tenths     (current_tenths),
    .temperature_tenths (temperature_tenths),
    .source_device      (source_device),
    .command_code       (command_code)
);

`default_nettype wire
